// ----- src/sha_pkg.sv -----
// shared constants and functions for the sha-256 stream hasher
package sha_pkg;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LEN_POS = 56;
	localparam int unsigned CNT_W = 61;

	// buffer load selection
	typedef enum logic [1:0] {
		LD_BYTE,
		LD_PAD,
		LD_ZERO,
		LD_LEN
	} load_sel_t;

	typedef struct packed {
		logic      load;       // write one byte slot
		load_sel_t load_sel;
		logic [5:0] load_pos;
		logic      cnt_inc;
		logic      cnt_clear;
		logic      comp_start; // load working vars from the hash
		logic      round;      // one compression round
		logic [5:0] round_idx;
		logic      hash_add;   // fold working vars into hash
		logic      hash_init;
		logic      out_load;   // capture digest into output shifter
		logic      out_shift;
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] cnt_pos;   // byte_count mod 64
	} sha_stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- src/sha_datapath.sv -----
// sha-256 datapath: block buffer, schedule, round unit, hash and digest shifter
module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sha_cmd_t    cmd,
	input  logic [7:0]  data_byte,
	output sha_stat_t   stat,
	output logic [31:0] digest_word
);

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] dig_q [8];
	logic [CNT_W-1:0] cnt_q;
	logic [63:0] bits;
	logic [7:0]  load_val;
	logic [31:0] w_new, w_use, s0, s1, t1, t2, ch, maj, e, a;

	assign bits = {cnt_q, 3'b000};
	assign stat.cnt_pos = cnt_q[5:0];

	always_comb begin
		case (cmd.load_sel)
			LD_BYTE: load_val = data_byte;
			LD_PAD:  load_val = PAD_BYTE;
			LD_ZERO: load_val = 8'h00;
			LD_LEN:  load_val = bits[{~cmd.load_pos[2:0], 3'b000} +: 8];
			default: load_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clear) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// rolling schedule: window shifts by one each round, w_q[0] is w[t]
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = s1 + w_q[9] + s0 + w_q[0];
	assign w_use = w_q[0];

	assign e = v_q[4];
	assign a = v_q[0];
	assign ch = (e & v_q[5]) ^ (~e & v_q[6]);
	assign maj = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
		+ ROUND_K[cmd.round_idx] + w_use;
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;

	// message bytes land big-endian straight in the schedule window
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end else if (cmd.load) begin
			w_q[cmd.load_pos[5:2]][{~cmd.load_pos[1:0], 3'b000} +: 8] <= load_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comp_start) begin
			for (int j = 0; j < 8; j++) v_q[j] <= hash_q[j];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) hash_q[j] <= IV[j];
		end else if (cmd.hash_init) begin
			for (int j = 0; j < 8; j++) hash_q[j] <= IV[j];
		end else if (cmd.hash_add) begin
			for (int j = 0; j < 8; j++) hash_q[j] <= hash_q[j] + v_q[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int j = 0; j < 8; j++) dig_q[j] <= hash_q[j];
		end else if (cmd.out_shift) begin
			for (int j = 0; j < 7; j++) dig_q[j] <= dig_q[j+1];
			dig_q[7] <= 32'h0;
		end
	end

	assign digest_word = dig_q[0];

endmodule

// ----- src/sha_ctrl.sv -----
// sha-256 sequencer: byte loads, padding, rounds and digest output
module sha_ctrl import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      has_byte,
	input  logic      last,
	input  sha_stat_t stat,
	output sha_cmd_t  cmd,
	output logic      m_tvalid,
	input  logic      m_tready,
	output logic      m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_DIG,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [5:0] idx_q;
	logic fin_q;    // finishing a message
	logic second_q; // pad byte already placed in the previous block
	logic len_q;    // length went into the block being compressed
	logic [2:0] ocnt_q;
	logic accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast = (ocnt_q == 3'd7);

	always_comb begin
		cmd = '0;
		cmd.load_sel = LD_BYTE;
		cmd.round_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && has_byte) begin
					cmd.load = 1'b1;
					cmd.load_pos = stat.cnt_pos;
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_START: cmd.comp_start = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD: begin
				cmd.hash_add = 1'b1;
			end
			ST_PAD: begin
				cmd.load = 1'b1;
				cmd.load_pos = idx_q;
				cmd.load_sel = (idx_q == stat.cnt_pos && !second_q) ? LD_PAD : LD_ZERO;
			end
			ST_LEN: begin
				cmd.load = 1'b1;
				cmd.load_pos = idx_q;
				cmd.load_sel = LD_LEN;
			end
			ST_DIG: begin
				cmd.out_load = 1'b1;
				cmd.hash_init = 1'b1;
				cmd.cnt_clear = 1'b1;
			end
			ST_OUT: cmd.out_shift = m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			fin_q <= 1'b0;
			second_q <= 1'b0;
			len_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fin_q <= last;
						second_q <= 1'b0;
						len_q <= 1'b0;
						if (has_byte && stat.cnt_pos == 6'd63) begin
							state_q <= ST_START;
						end else if (last) begin
							state_q <= ST_PAD;
							idx_q <= has_byte ? stat.cnt_pos + 6'd1 : stat.cnt_pos;
						end
					end
				end
				ST_START: begin
					state_q <= ST_ROUND;
					idx_q <= '0;
				end
				ST_ROUND: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_q) begin
						state_q <= ST_DIG;
					end else begin
						// length still to go: pad a fresh block
						state_q <= ST_PAD;
						idx_q <= '0;
					end
				end
				ST_PAD: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd55) begin
						state_q <= ST_LEN;
					end else if (idx_q == 6'd63) begin
						// pad did not leave room for the length
						state_q <= ST_START;
						second_q <= 1'b1;
					end
				end
				ST_LEN: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) begin
						state_q <= ST_START;
						len_q <= 1'b1;
					end
				end
				ST_DIG: begin
					state_q <= ST_OUT;
					ocnt_q <= '0;
				end
				ST_OUT: begin
					if (m_tready) begin
						ocnt_q <= ocnt_q + 3'd1;
						if (ocnt_q == 3'd7) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/sha256_stream_hasher.sv -----
// top level of the sha-256 stream hasher
// Takes at most one message byte per request (s_tuser marks a byte) and returns
// the eight digest words, word 0 first, after a request with tlast set. Every
// 64th byte starts a compression through the single round unit. Finishing adds
// one or two padded blocks, each filled in the buffer and then run through the
// rounds, a digest capture and then eight output requests. One request is in
// work at a time.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // has_byte
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // digest_word
	output logic        m_tlast   // last_word
);

	sha_cmd_t  cmd;
	sha_stat_t stat;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.has_byte(s_tuser), .last(s_tlast),
		.stat(stat), .cmd(cmd),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .data_byte(s_tdata),
		.stat(stat), .digest_word(m_tdata)
	);

endmodule

// ----- tb/sha256_stream_hasher_tb.sv -----
// testbench for the sha-256 stream hasher: byte stream in, digest words checked
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;
	import sha_pkg::*;

	class digest_board;
		logic [31:0] hash_st [8];
		logic [7:0]  blk [64];
		logic [60:0] nbytes;
		logic [31:0] want_word [$];
		logic        want_last [$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) hash_st[i] = IV[i];
			nbytes = '0;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] wt, t1, t2, w2, w15;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			for (int j = 0; j < 8; j++) v[j] = hash_st[j];
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					w2 = w[(t-2) & 15];
					w15 = w[(t-15) & 15];
					wt = (ror(w2,17) ^ ror(w2,19) ^ (w2 >> 10)) + w[(t-7) & 15]
						+ (ror(w15,7) ^ ror(w15,18) ^ (w15 >> 3)) + w[t & 15];
					w[t & 15] = wt;
				end
				t1 = v[7] + (ror(v[4],6) ^ ror(v[4],11) ^ ror(v[4],25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
				t2 = (ror(v[0],2) ^ ror(v[0],13) ^ ror(v[0],22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int j = 0; j < 8; j++) hash_st[j] += v[j];
		endfunction

		function void note_request(logic [7:0] b, logic hb, logic lst);
			int unsigned p;
			logic [63:0] bits;
			if (hb) begin
				p = nbytes[5:0];
				blk[p] = b;
				nbytes++;
				if (p == 63) compress();
			end
			if (!lst) return;
			p = nbytes[5:0];
			blk[p] = PAD_BYTE;
			for (int j = p + 1; j < 64; j++) blk[j] = 8'h00;
			if (p >= LEN_POS) begin
				compress();
				for (int j = 0; j < 64; j++) blk[j] = 8'h00;
			end
			bits = {nbytes, 3'b000};
			for (int j = 0; j < 8; j++) blk[LEN_POS + 7 - j] = bits[8*j +: 8];
			compress();
			for (int j = 0; j < 8; j++) begin
				want_word.push_back(hash_st[j]);
				want_last.push_back(j == 7);
			end
			restart();
		endfunction

		function void check_word(logic [31:0] d, logic l);
			if (want_word.size() == 0) begin
				$error("digest_word: unexpected output %h", d);
				errors++;
				return;
			end
			if (d !== want_word[0]) begin
				$error("digest_word: expected %h, got %h", want_word[0], d);
				errors++;
			end
			if (l !== want_last[0]) begin
				$error("last_word: expected %b, got %b", want_last[0], l);
				errors++;
			end
			void'(want_word.pop_front());
			void'(want_last.pop_front());
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser, s_tlast;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [31:0] m_tdata;
	logic        hold_off;
	digest_board board;

	sha256_stream_hasher dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk)
		if (s_tvalid && s_tready) board.note_request(s_tdata, s_tuser, s_tlast);

	always @(posedge clk)
		if (m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);

	// receiver: random stalls, long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic send(logic [7:0] b, logic hb, logic lst, bit bursty);
		int gap;
		gap = bursty ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= hb;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.want_word.size() != 0) @(posedge clk);
	endtask

	task automatic message(int len, bit bursty);
		for (int i = 0; i < len; i++)
			send($urandom_range(0, 255), 1'b1, (i == len - 1), bursty);
		if (len == 0) send($urandom_range(0, 255), 1'b0, 1'b1, bursty);
	endtask

	initial begin
		board = new();
		hold_off = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, idle items, byte extremes, byte with last, abc closed by an idle last
		send(8'h00, 1'b0, 1'b1, 0);
		send(8'hff, 1'b0, 1'b0, 0);
		send(8'h00, 1'b1, 1'b0, 0);
		send(8'hff, 1'b1, 1'b0, 0);
		send(8'ha5, 1'b0, 1'b0, 0);
		send(8'h5a, 1'b1, 1'b1, 0);
		send(8'h61, 1'b1, 1'b0, 0);
		send(8'h62, 1'b1, 1'b0, 0);
		send(8'h63, 1'b1, 1'b0, 0);
		send(8'h00, 1'b0, 1'b1, 0);
		drain();

		// block boundaries: length spilling into a second block, full block and short message under receiver hold-off
		message(56, 0);
		drain();
		hold_off = 1'b1;
		message(64, 1);
		message(3, 1);
		hold_off = 1'b0;
		drain();

		// random short messages with stray idle items
		for (int n = 0; n < 8; n++) begin
			if ($urandom_range(0, 4) == 0)
				send($urandom_range(0, 255), 1'b0, 1'b0, 0);
			message($urandom_range(0, 9), $urandom_range(0, 3) == 0);
		end
		drain();
		repeat (300) @(posedge clk);

		if (board.errors == 0 && board.want_word.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sha_pkg.sv
src/sha_datapath.sv
src/sha_ctrl.sv
src/sha256_stream_hasher.sv
tb/sha256_stream_hasher_tb.sv
